// File: rtl/core/inu_pkg.sv
// ----------------------------------------------------------------------------
// inu_pkg
// Shared types and constants of the integer nearest-neighbor upscaler.
// ----------------------------------------------------------------------------
package inu_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // input operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [6:0] SCALE_LIMIT = 7'd100;
  localparam logic [7:0] PAD_BYTE    = 8'h00;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // classified result of one accepted word
  typedef struct packed {
    logic push_accepted;
    logic out_valid;
    logic is_padding;
    logic end_of_row;
    logic end_of_image;
    logic pixel_read;
  } inu_desc_t;

  // queue entry: descriptor plus line store read data
  typedef struct packed {
    inu_desc_t   desc;
    logic [23:0] pixel;
  } inu_item_t;

endpackage

// File: rtl/core/integer_nearest_upscaler.sv
// ----------------------------------------------------------------------------
// integer_nearest_upscaler
// Nearest-neighbor integer upscaler for 24-bit pixels with row padding.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per operation: tuser is the operation (0 push a
//   pixel into the line store, 1 pull the next output item), tdata the pixel.
//   Every accepted word gives exactly one result word on m_axis: tuser holds
//   push_accepted, out_valid, is_padding and end_of_image, tlast marks the
//   end of an output row, tdata the pixel (zero for padding and pushes).
//   Configuration (scale, width, height) is written on cfg_write/cfg_index/
//   cfg_data while the block is idle.
//   Throughput is one word per cycle while s_axis_tready is high. From
//   acceptance to m_axis_tvalid a word passes the row counters and registered
//   line store read, the front/back queue, then the output register.
//   A stall on m_axis fills the 4-entry queue; s_axis_tready drops only when
//   the queue and the word in flight would overflow it.
//   Reset clears counters and config to their defaults; the line store is
//   not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module integer_nearest_upscaler #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue_in, green_in, red_in
  input  logic [0:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // blue_out, green_out, red_out
  output logic [3:0]  m_axis_tuser,   // push_accepted, out_valid, is_padding, end_of_image
  output logic        m_axis_tlast    // end_of_row
);
  import inu_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [23:0]   ram_wr_data, ram_rd_data;
  logic          desc_valid;
  inu_desc_t     desc;
  inu_item_t     push_item, q_head;
  logic          q_not_empty, q_pop, q_space;

  assign s_axis_tready = q_space;
  assign push_item     = '{desc: desc, pixel: ram_rd_data};

  inu_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (q_space),
    .in_op       (s_axis_tuser[0]),
    .in_pixel    (s_axis_tdata),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .desc_valid  (desc_valid),
    .desc        (desc)
  );

  inu_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH), .AW(AW)) u_line_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  inu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_valid),
    .push_item (push_item),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .space     (q_space)
  );

  inu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (m_axis_tvalid),
    .out_tready  (m_axis_tready),
    .out_tdata   (m_axis_tdata),
    .out_tuser   (m_axis_tuser),
    .out_tlast   (m_axis_tlast)
  );

endmodule

// File: rtl/core/inu_ram.sv
// ----------------------------------------------------------------------------
// inu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module inu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/inu_front.sv
// ----------------------------------------------------------------------------
// inu_front
// Accepts push/pull words, keeps the row counters, drives the line store.
// ----------------------------------------------------------------------------
module inu_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_op,
  input  logic [23:0]         in_pixel,
  output logic                ram_wr_en,
  output logic [AW-1:0]       ram_wr_addr,
  output logic [23:0]         ram_wr_data,
  output logic                ram_rd_en,
  output logic [AW-1:0]       ram_rd_addr,
  output logic                desc_valid,
  output inu_pkg::inu_desc_t  desc
);
  import inu_pkg::*;

  // configuration registers
  logic [6:0]  scale_factor;
  logic [10:0] source_width;
  logic [15:0] source_height;

  // row state
  logic [10:0] write_column, write_column_next;
  logic        row_ready, row_ready_next;
  logic [10:0] read_column, read_column_next;
  logic [6:0]  horizontal_repeat, horizontal_repeat_next;
  logic [6:0]  vertical_repeat, vertical_repeat_next;
  logic [1:0]  padding_left, padding_left_next;
  logic [15:0] rows_completed, rows_completed_next;
  inu_desc_t   desc_next;

  logic        accept;
  logic [6:0]  eff_scale;
  logic [10:0] eff_width;
  logic [15:0] eff_height;
  logic [10:0] wcol_inc, rcol_inc;
  logic [6:0]  hrep_inc, vrep_inc;
  logic [15:0] rows_inc;
  logic [1:0]  pad_count;
  logic        row_end;

  assign accept = in_valid && in_ready;

  // clamped configuration
  always_comb begin
    if (scale_factor == 7'd0) begin
      eff_scale = 7'd1;
    end else if (scale_factor > SCALE_LIMIT) begin
      eff_scale = SCALE_LIMIT;
    end else begin
      eff_scale = scale_factor;
    end
    if (source_width == 11'd0) begin
      eff_width = 11'd1;
    end else if (32'(source_width) > MAX_WIDTH) begin
      eff_width = 11'(MAX_WIDTH);
    end else begin
      eff_width = source_width;
    end
    eff_height = (source_height == 16'd0) ? 16'd1 : source_height;
  end

  assign wcol_inc  = write_column + 11'd1;
  assign rcol_inc  = read_column + 11'd1;
  assign hrep_inc  = horizontal_repeat + 7'd1;
  assign vrep_inc  = vertical_repeat + 7'd1;
  assign rows_inc  = rows_completed + 16'd1;
  // (w * s) mod 4 from the low bits only
  assign pad_count = 2'(eff_width[1:0] * eff_scale[1:0]);

  // line store access
  assign ram_wr_addr = AW'(write_column);
  assign ram_wr_data = in_pixel;
  assign ram_rd_addr = AW'(read_column);

  // next state and descriptor
  always_comb begin
    write_column_next      = write_column;
    row_ready_next         = row_ready;
    read_column_next       = read_column;
    horizontal_repeat_next = horizontal_repeat;
    vertical_repeat_next   = vertical_repeat;
    padding_left_next      = padding_left;
    rows_completed_next    = rows_completed;
    desc_next              = '0;
    ram_wr_en              = 1'b0;
    ram_rd_en              = 1'b0;
    row_end                = 1'b0;
    if (accept && in_op == OP_PUSH && !row_ready) begin
      ram_wr_en               = (32'(write_column) < MAX_WIDTH);
      desc_next.push_accepted = 1'b1;
      write_column_next       = wcol_inc;
      if (wcol_inc >= eff_width) begin
        write_column_next      = 11'd0;
        row_ready_next         = 1'b1;
        read_column_next       = 11'd0;
        horizontal_repeat_next = 7'd0;
        vertical_repeat_next   = 7'd0;
        padding_left_next      = 2'd0;
      end
    end else if (accept && in_op == OP_PULL && row_ready) begin
      desc_next.out_valid = 1'b1;
      if (padding_left != 2'd0) begin
        // padding byte of the current row
        desc_next.is_padding = 1'b1;
        padding_left_next    = padding_left - 2'd1;
        row_end              = (padding_left == 2'd1);
      end else begin
        // pixel from the line store
        ram_rd_en              = 1'b1;
        desc_next.pixel_read   = (32'(read_column) < MAX_WIDTH);
        horizontal_repeat_next = hrep_inc;
        if (hrep_inc >= eff_scale) begin
          horizontal_repeat_next = 7'd0;
          read_column_next       = rcol_inc;
          if (rcol_inc >= eff_width) begin
            read_column_next  = 11'd0;
            padding_left_next = pad_count;
            row_end           = (pad_count == 2'd0);
          end
        end
      end
      // end of an output row
      if (row_end) begin
        desc_next.end_of_row = 1'b1;
        vertical_repeat_next = vrep_inc;
        if (vrep_inc >= eff_scale) begin
          vertical_repeat_next = 7'd0;
          row_ready_next       = 1'b0;
          rows_completed_next  = rows_inc;
          if (rows_inc == 16'd0 || rows_inc >= eff_height) begin
            rows_completed_next    = 16'd0;
            desc_next.end_of_image = 1'b1;
          end
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= 7'd1;
      source_width  <= 11'd1;
      source_height <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE:  scale_factor  <= cfg_data[6:0];
        REG_WIDTH:  source_width  <= cfg_data[10:0];
        REG_HEIGHT: source_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_column      <= 11'd0;
      row_ready         <= 1'b0;
      read_column       <= 11'd0;
      horizontal_repeat <= 7'd0;
      vertical_repeat   <= 7'd0;
      padding_left      <= 2'd0;
      rows_completed    <= 16'd0;
      desc_valid        <= 1'b0;
    end else begin
      write_column      <= write_column_next;
      row_ready         <= row_ready_next;
      read_column       <= read_column_next;
      horizontal_repeat <= horizontal_repeat_next;
      vertical_repeat   <= vertical_repeat_next;
      padding_left      <= padding_left_next;
      rows_completed    <= rows_completed_next;
      desc_valid        <= accept;
    end
  end

  // descriptor lines up with the registered ram read
  always_ff @(posedge clk) begin
    desc <= desc_next;
  end

endmodule

// File: rtl/core/inu_queue.sv
// ----------------------------------------------------------------------------
// inu_queue
// Short queue between front and back, with credit for the word in flight.
// ----------------------------------------------------------------------------
module inu_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  inu_pkg::inu_item_t push_item,
  input  logic               pop,
  output logic               not_empty,
  output inu_pkg::inu_item_t head,
  output logic               space
);
  import inu_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 2);

  inu_item_t     entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;
  // one word may already sit in the front stage
  assign space     = (count + CW'(push)) < CW'(QUEUE_DEPTH);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

endmodule

// File: rtl/core/inu_back.sv
// ----------------------------------------------------------------------------
// inu_back
// Formats queued results and holds them in the output register.
// ----------------------------------------------------------------------------
module inu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  inu_pkg::inu_item_t q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,
  output logic [3:0]         out_tuser,
  output logic               out_tlast
);
  import inu_pkg::*;

  logic [23:0] pixel;

  // pixel fields are zero unless read from the line store
  assign pixel = q_head.desc.pixel_read ? q_head.pixel : {3{PAD_BYTE}};
  assign q_pop = q_not_empty && (!out_tvalid || out_tready);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (q_pop) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_tdata <= pixel;
      out_tuser <= {q_head.desc.end_of_image, q_head.desc.is_padding,
                    q_head.desc.out_valid, q_head.desc.push_accepted};
      out_tlast <= q_head.desc.end_of_row;
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_nearest_upscaler testbench
// Drives push and pull words on the slave stream and checks every result word
// against a cycle-free model of line store, repeat counters and row padding
// (or a known table result). A directed table runs first. Extreme register
// settings follow, then random rows under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
  import inu_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int STIM_ROWS = 23;
  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // one result word: flags, then pixel as {red, green, blue}
  typedef struct packed {
    logic        push_accepted;
    logic        out_valid;
    logic        is_padding;
    logic        end_of_image;
    logic        end_of_row;
    logic [23:0] pixel;
  } upscale_word_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } reg_write_t;

  // directed table row: a register write or a word, optionally with a known result
  typedef struct packed {
    logic          is_cfg;
    logic [1:0]    index;
    logic [15:0]   value;
    logic          op;
    logic [23:0]   pixel;
    logic          typed;
    upscale_word_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // blue_in, green_in, red_in
  logic [0:0]  s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // blue_out, green_out, red_out
  logic [3:0]  m_axis_tuser;   // push_accepted, out_valid, is_padding, end_of_image
  logic        m_axis_tlast;   // end_of_row

  integer_nearest_upscaler #(
    .MAX_WIDTH(LINE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // model state
  logic [6:0]  cfg_scale;
  logic [10:0] cfg_width;
  logic [15:0] cfg_height;
  logic [23:0] line_mem [LINE_DEPTH];
  logic [10:0] wr_col;
  logic [10:0] rd_col;
  logic        row_full;
  logic [6:0]  h_rep;
  logic [6:0]  v_rep;
  logic [1:0]  pad_left;
  logic [15:0] rows_done;

  upscale_word_t expected_words[$];
  reg_write_t    reg_writes[$];
  stim_row_t     stim_table [0:STIM_ROWS-1];

  int mismatch_count = 0;
  int useful_words = 0;
  int source_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_off_len = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("integer_nearest_upscaler verification failed");
    $finish;
  end

  // next result word of the upscaler for one accepted word
  function automatic upscale_word_t upscale_step(logic op, logic [23:0] pixel);
    upscale_word_t r;
    int w;
    int s;
    bit row_end;
    r = '0;
    w = (cfg_width == 0) ? 1 : (cfg_width > LINE_DEPTH) ? LINE_DEPTH : cfg_width;
    s = (cfg_scale == 0) ? 1 : (cfg_scale > SCALE_LIMIT) ? SCALE_LIMIT : cfg_scale;
    row_end = 1'b0;
    if (op == OP_PUSH) begin
      // refused while a stored row is being replayed
      if (row_full) return r;
      if (wr_col < LINE_DEPTH) line_mem[wr_col[9:0]] = pixel;
      wr_col = wr_col + 11'd1;
      if (wr_col >= w) begin
        wr_col = '0;
        row_full = 1'b1;
        rd_col = '0;
        h_rep = '0;
        v_rep = '0;
        pad_left = '0;
      end
      r.push_accepted = 1'b1;
      return r;
    end
    if (!row_full) return r;
    r.out_valid = 1'b1;
    if (pad_left != 0) begin
      r.is_padding = 1'b1;
      r.pixel = {PAD_BYTE, PAD_BYTE, PAD_BYTE};
      pad_left = pad_left - 2'd1;
      if (pad_left == 0) row_end = 1'b1;
    end else begin
      // columns past the line store read as zero
      r.pixel = (rd_col < LINE_DEPTH) ? line_mem[rd_col[9:0]] : 24'h000000;
      h_rep = h_rep + 7'd1;
      if (h_rep >= s) begin
        h_rep = '0;
        rd_col = rd_col + 11'd1;
        if (rd_col >= w) begin
          rd_col = '0;
          pad_left = 2'((w * s) % 4);
          if (pad_left == 0) row_end = 1'b1;
        end
      end
    end
    if (row_end) begin
      r.end_of_row = 1'b1;
      v_rep = v_rep + 7'd1;
      if (v_rep >= s) begin
        v_rep = '0;
        row_full = 1'b0;
        rows_done = rows_done + 16'd1;
        if (rows_done == 0 || rows_done >= ((cfg_height == 0) ? 1 : cfg_height)) begin
          rows_done = '0;
          r.end_of_image = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // flags from push_accepted down to end_of_row, pixel zero
  function automatic upscale_word_t flags_word(logic [4:0] flags);
    flags_word = {flags, 24'h000000};
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] index, logic [15:0] value);
    cfg_row = '0;
    cfg_row.is_cfg = 1'b1;
    cfg_row.index = index;
    cfg_row.value = value;
  endfunction

  function automatic stim_row_t word_row(logic op, logic [23:0] pixel);
    word_row = '0;
    word_row.op = op;
    word_row.pixel = pixel;
  endfunction

  function automatic stim_row_t known_row(logic op, logic [23:0] pixel, upscale_word_t want);
    known_row = word_row(op, pixel);
    known_row.typed = 1'b1;
    known_row.want = want;
  endfunction

  // offer one word, record its expected result once accepted
  task automatic send_word(input logic op, input logic [23:0] pixel, input logic typed,
                           input upscale_word_t want);
    upscale_word_t r;
    while ($urandom_range(99) < source_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= pixel;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = upscale_step(op, pixel);
    if (r.push_accepted || r.out_valid) useful_words++;
    expected_words.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic queue_write(input logic [1:0] index, input logic [15:0] value);
    reg_writes.push_back({index, value});
  endtask

  // back-to-back register writes once the block is idle
  task automatic apply_reg_writes();
    reg_write_t wr;
    wait_for_results();
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg_write <= 1'b1;
      cfg_index <= wr.index;
      cfg_data <= wr.value;
      case (wr.index)
        REG_SCALE:  cfg_scale = wr.value[6:0];
        REG_WIDTH:  cfg_width = wr.value[10:0];
        REG_HEIGHT: cfg_height = wr.value;
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] scale, input logic [15:0] width,
                           input logic [15:0] height);
    queue_write(REG_SCALE, scale);
    queue_write(REG_WIDTH, width);
    queue_write(REG_HEIGHT, height);
    apply_reg_writes();
  endtask

  // pull the stored row out to its last repeat
  task automatic finish_row();
    while (row_full) send_word(OP_PULL, 24'($urandom), 1'b0, '0);
  endtask

  // fill one row with random pixels and replay it, with some ignored words mixed in
  task automatic run_row();
    while (!row_full) begin
      if ($urandom_range(9) == 0) send_word(OP_PULL, 24'($urandom), 1'b0, '0);
      send_word(OP_PUSH, 24'($urandom), 1'b0, '0);
    end
    while (row_full) begin
      if ($urandom_range(12) == 0) send_word(OP_PUSH, 24'($urandom), 1'b0, '0);
      else send_word(OP_PULL, 24'($urandom), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    upscale_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: tuser %h tdata %h tlast %b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("push_accepted", 24'(want.push_accepted), 24'(m_axis_tuser[0]));
        check_field("out_valid", 24'(want.out_valid), 24'(m_axis_tuser[1]));
        check_field("is_padding", 24'(want.is_padding), 24'(m_axis_tuser[2]));
        check_field("end_of_image", 24'(want.end_of_image), 24'(m_axis_tuser[3]));
        check_field("end_of_row", 24'(want.end_of_row), 24'(m_axis_tlast));
        check_field("blue_out", 24'(want.pixel[7:0]), 24'(m_axis_tdata[7:0]));
        check_field("green_out", 24'(want.pixel[15:8]), 24'(m_axis_tdata[15:8]));
        check_field("red_out", 24'(want.pixel[23:16]), 24'(m_axis_tdata[23:16]));
      end
    end
  end

  // main sequence
  initial begin
    int phase;
    int goal;
    bit big;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SCALE;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_PUSH;
    cfg_scale = 7'd1;
    cfg_width = 11'd1;
    cfg_height = 16'd1;
    wr_col = '0;
    rd_col = '0;
    row_full = 1'b0;
    h_rep = '0;
    v_rep = '0;
    pad_left = '0;
    rows_done = '0;

    // directed table, starting from the reset geometry of one pixel, scale one
    stim_table[0]  = known_row(OP_PULL, 24'hFFFFFF, flags_word(5'b00000)); // nothing stored
    stim_table[1]  = known_row(OP_PUSH, 24'h000000, flags_word(5'b10000));
    stim_table[2]  = known_row(OP_PUSH, 24'hFFFFFF, flags_word(5'b00000)); // row waiting
    stim_table[3]  = known_row(OP_PULL, 24'h000000, flags_word(5'b01000));
    stim_table[4]  = known_row(OP_PULL, 24'h000000, flags_word(5'b01111)); // pad, end
    // zero registers act as one, unused index changes nothing
    stim_table[5]  = cfg_row(REG_SCALE, 16'h0000);
    stim_table[6]  = cfg_row(REG_WIDTH, 16'h0000);
    stim_table[7]  = cfg_row(REG_HEIGHT, 16'h0000);
    stim_table[8]  = cfg_row(REG_UNUSED, 16'hFFFF);
    stim_table[9]  = known_row(OP_PUSH, 24'hA55AC3, flags_word(5'b10000));
    stim_table[10] = word_row(OP_PULL, 24'h5AA53C);
    stim_table[11] = word_row(OP_PULL, 24'h000000);
    // two pixels, doubled, two rows
    stim_table[12] = cfg_row(REG_SCALE, 16'd2);
    stim_table[13] = cfg_row(REG_WIDTH, 16'd2);
    stim_table[14] = cfg_row(REG_HEIGHT, 16'd2);
    stim_table[15] = word_row(OP_PUSH, 24'h123456);
    stim_table[16] = word_row(OP_PUSH, 24'hFEDCBA);
    stim_table[17] = known_row(OP_PUSH, 24'h0F0F0F, flags_word(5'b00000));
    for (int i = 18; i < STIM_ROWS; i++) stim_table[i] = word_row(OP_PULL, 24'hFFFFFF);

    // reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < STIM_ROWS; i++) begin
      if (stim_table[i].is_cfg) begin
        reg_writes.push_back({stim_table[i].index, stim_table[i].value});
      end else begin
        if (reg_writes.size() != 0) apply_reg_writes();
        send_word(stim_table[i].op, stim_table[i].pixel, stim_table[i].typed,
                  stim_table[i].want);
      end
    end
    finish_row();

    // register extremes: saturated scale under a long receiver hold-off
    configure(16'hFFFF, 16'd1, 16'hFFFF);
    hold_off_len = 400;
    send_word(OP_PUSH, 24'($urandom), 1'b0, '0);
    // one whole output row at the limit scale, one word into the next
    repeat (101) send_word(OP_PULL, 24'($urandom), 1'b0, '0);
    // shrink the scale mid-row, the counters already past it
    configure(16'd1, 16'd1, 16'd1);
    finish_row();
    // zero height acts as one
    configure(16'd1, 16'd3, 16'd0);
    run_row();

    // random rows under each idling mix
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin source_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin source_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin source_idle_pct = 17; sink_stall_pct = 17; end
      endcase
      goal = useful_words + 80;
      while (useful_words < goal) begin
        if ($urandom_range(2) == 0) begin
          big = ($urandom_range(7) == 0);
          if ($urandom_range(2) != 0)
            queue_write(REG_SCALE, 16'(big ? $urandom_range(6) : $urandom_range(4)));
          if ($urandom_range(2) != 0)
            queue_write(REG_WIDTH, 16'(big ? $urandom_range(16) : $urandom_range(10)));
          if ($urandom_range(2) != 0) queue_write(REG_HEIGHT, 16'($urandom_range(3)));
          if (reg_writes.size() != 0) apply_reg_writes();
        end
        run_row();
      end
    end

    // drain, then watch for stray words
    wait_for_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("integer_nearest_upscaler verification clean");
    end else begin
      $display("integer_nearest_upscaler verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/inu_pkg.sv
rtl/core/inu_ram.sv
rtl/core/inu_front.sv
rtl/core/inu_queue.sv
rtl/core/inu_back.sv
rtl/core/integer_nearest_upscaler.sv
verif/testbench.sv
